// File: rtl/flow_toeplitz_hash_bucket_macros.svh
// ----------------------------------------------------------------------------
// Flow Toeplitz hash bucket - assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FLOW_TOEPLITZ_HASH_BUCKET_MACROS_SVH
`define FLOW_TOEPLITZ_HASH_BUCKET_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TTH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tth assertion failed");
// next-cycle implication
`define TTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tth assertion failed");
`else
`define TTH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TTH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/tth_pkg.sv
// ----------------------------------------------------------------------------
// tth_pkg
// Types, register indexes and hash helpers for the flow Toeplitz hash block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tth_pkg;

    localparam int KEY_W    = 128;
    localparam int HASH_W   = 32;
    localparam int DIGIT_W  = 8;
    localparam int DIV_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT  = 2'd3;

    localparam logic [DIV_W-1:0] BUCKET_MAX = 9'd256;

    typedef struct packed {
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic [15:0] host_port;
    } in_t;

    typedef struct packed {
        logic [31:0] raw_hash;
        logic [7:0]  bucket;
    } out_t;

    // partial hashes, one per tuple word
    typedef struct packed {
        logic [HASH_W-1:0] p_remote;
        logic [HASH_W-1:0] p_local;
        logic [HASH_W-1:0] p_ports;
    } part_t;

    // beat moving through the modulo stages
    typedef struct packed {
        logic [HASH_W-1:0]  raw_hash;
        logic [DIGIT_W-1:0] rem;
    } mod_beat_t;

    // XOR of the key windows selected by the set bits of one 32-bit tuple word;
    // base is the tuple bit position of the word's msb
    function automatic logic [HASH_W-1:0] word_hash(
        input logic [31:0]      word,
        input logic [KEY_W-1:0] key,
        input int               base
    );
        logic [HASH_W-1:0] h;
        logic [KEY_W-1:0]  sh;
        h = '0;
        for (int b = 0; b < 32; b++) begin
            sh = key << (base + b);
            if (word[31-b]) begin
                h = h ^ sh[KEY_W-1 -: HASH_W];
            end
        end
        return h;
    endfunction

endpackage

// File: rtl/tth_hash_stage.sv
// ----------------------------------------------------------------------------
// tth_hash_stage
// First pipeline stage: registered per-word partial Toeplitz hashes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tth_hash_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tth_pkg::in_t               in_data,
    input  logic [tth_pkg::KEY_W-1:0]  key,
    input  logic [31:0]                local_address,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tth_pkg::part_t             out_part
);
    import tth_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    part_t part_reg;
    part_t part_next;
    logic  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        part_next.p_remote = word_hash(in_data.remote_ip, key, 0);
        part_next.p_local  = word_hash(local_address, key, 32);
        part_next.p_ports  = word_hash({in_data.remote_port, in_data.host_port}, key, 64);
        valid_next         = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            part_reg <= part_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_part  = part_reg;

endmodule

// File: rtl/tth_mod_stage.sv
// ----------------------------------------------------------------------------
// tth_mod_stage
// One modulo stage: eight restoring reduction steps over one hash byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tth_mod_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tth_pkg::mod_beat_t            in_beat,
    input  logic [tth_pkg::DIGIT_W-1:0]   digits,
    input  logic [tth_pkg::DIV_W-1:0]     divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tth_pkg::mod_beat_t            out_beat
);
    import tth_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    mod_beat_t beat_reg;
    mod_beat_t beat_next;
    logic      load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // remainder stays below divisor (<= 256), so it fits one byte
    always_comb
    begin
        logic [DIGIT_W-1:0] r;
        logic [DIV_W-1:0]   t;
        r = in_beat.rem;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            t = {r, digits[i]};
            if (t >= divisor) begin
                t = t - divisor;
            end
            r = t[DIGIT_W-1:0];
        end
        beat_next.raw_hash = in_beat.raw_hash;
        beat_next.rem      = r;
        valid_next         = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// File: rtl/flow_toeplitz_hash_bucket.sv
// ----------------------------------------------------------------------------
// flow_toeplitz_hash_bucket
// Toeplitz RSS hash of an IPv4 flow tuple, reduced to a worker bucket.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready/in_data) carry remote address and ports;
//   the local address and 128-bit key come from configuration registers.
//   Each input beat yields one output beat (out_valid/out_ready/out_data)
//   with the 32-bit hash and hash modulo the bucket count.
//   An accepted beat reaches out_valid through one hash stage, then
//   four modulo stages of eight reduction steps each (one hash byte apiece).
//   Throughput is one beat per cycle; every stage holds one beat and moves
//   it on whenever the stage after it is empty or being drained.
//   When the receiver stalls, the stages fill up behind the output register
//   and in_ready drops only once all five are full; nothing is dropped.
//   Reset clears the stage valid bits, zeroes key and local address, and
//   sets bucket count to 1. Configuration writes take effect at once and
//   belong in idle periods. A bucket count of 0 acts as 1, above 256 as 256.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flow_toeplitz_hash_bucket_macros.svh"

module flow_toeplitz_hash_bucket (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tth_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tth_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tth_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tth_pkg::out_t                   out_data
);
    import tth_pkg::*;

    localparam int MOD_STAGES = HASH_W / DIGIT_W;

    // configuration registers
    logic [63:0]      key_upper_reg;
    logic [63:0]      key_lower_reg;
    logic [31:0]      local_address_reg;
    logic [DIV_W-1:0] bucket_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg     <= '0;
            key_lower_reg     <= '0;
            local_address_reg <= '0;
            bucket_count_reg  <= DIV_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY_UPPER:     key_upper_reg     <= cfg_data;
                REG_KEY_LOWER:     key_lower_reg     <= cfg_data;
                REG_LOCAL_ADDRESS: local_address_reg <= cfg_data[31:0];
                REG_BUCKET_COUNT:  bucket_count_reg  <= cfg_data[DIV_W-1:0];
                default:           ;
            endcase
        end
    end

    // effective divisor: clamp into 1..256
    logic [DIV_W-1:0] divisor;
    always_comb
    begin
        if (bucket_count_reg == '0)
            divisor = DIV_W'(1);
        else if (bucket_count_reg > BUCKET_MAX)
            divisor = BUCKET_MAX;
        else
            divisor = bucket_count_reg;
    end

    // stage 1: partial hashes per tuple word
    logic  ha_valid;
    logic  ha_ready;
    part_t ha_part;

    tth_hash_stage u_hash (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .key           ({key_upper_reg, key_lower_reg}),
        .local_address (local_address_reg),
        .out_valid     (ha_valid),
        .out_ready     (ha_ready),
        .out_part      (ha_part)
    );

    // fold partials; first modulo stage starts from a zero remainder
    mod_beat_t fold_beat;
    assign fold_beat.raw_hash = ha_part.p_remote ^ ha_part.p_local ^ ha_part.p_ports;
    assign fold_beat.rem      = '0;

    // stages 2..5: modulo reduction, msb byte first
    logic      m_valid [MOD_STAGES];
    logic      m_ready [MOD_STAGES];
    mod_beat_t m_beat  [MOD_STAGES];

    tth_mod_stage u_mod0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ha_valid),
        .in_ready  (ha_ready),
        .in_beat   (fold_beat),
        .digits    (fold_beat.raw_hash[HASH_W-1 -: DIGIT_W]),
        .divisor   (divisor),
        .out_valid (m_valid[0]),
        .out_ready (m_ready[0]),
        .out_beat  (m_beat[0])
    );

    for (genvar g = 1; g < MOD_STAGES; g++) begin : g_mod
        tth_mod_stage u_mod (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (m_valid[g-1]),
            .in_ready  (m_ready[g-1]),
            .in_beat   (m_beat[g-1]),
            .digits    (m_beat[g-1].raw_hash[HASH_W-1-DIGIT_W*g -: DIGIT_W]),
            .divisor   (divisor),
            .out_valid (m_valid[g]),
            .out_ready (m_ready[g]),
            .out_beat  (m_beat[g])
        );
    end

    assign out_valid                   = m_valid[MOD_STAGES-1];
    assign m_ready[MOD_STAGES-1]       = out_ready;
    assign out_data.raw_hash           = m_beat[MOD_STAGES-1].raw_hash;
    assign out_data.bucket             = m_beat[MOD_STAGES-1].rem;

    // an empty output stage means every stage can take a beat
    `TTH_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
    // an accepted input lands in the hash stage
    `TTH_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_valid && in_ready, ha_valid)
    // a hash-stage beat moves into the first modulo stage when it is free
    `TTH_ASSERT_NEXT(a_hash_advances, clk, rst_n, ha_valid && ha_ready, m_valid[0])

endmodule
